FILE: design/pitot_pkg.sv
package pitot_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRES,
    ST_SCALE,
    ST_DIV,
    ST_SQRT_GO,
    ST_SQRT,
    ST_ACC,
    ST_BIAS_GO,
    ST_BIAS_DIV,
    ST_BIAS_SET,
    ST_DONE
  } pitot_state_e;

  typedef enum logic [0:0] {
    MODE_DIV,
    MODE_SQRT
  } pitot_mode_e;

  typedef struct packed {
    logic        start;
    pitot_mode_e mode;
  } pitot_iter_req_t;

  localparam logic [1:0] KIND_MEASURE = 2'd0;
  localparam logic [1:0] KIND_CAL     = 2'd1;
  localparam logic [1:0] KIND_FINISH  = 2'd2;

  localparam int ROM_SIZE = 66;
  localparam int IDX_W    = $clog2(ROM_SIZE);
  localparam int ROM_W    = 11;
  localparam int RHO_W    = 19;
  localparam int MAG_W    = 30;
  localparam int MUL_W    = 40;
  localparam int SCALE_W  = MUL_W + 9;
  localparam int SQRT_W   = 32;
  localparam int ROOT_W   = 16;
  localparam int TERM_W   = 20;
  localparam int BIAS_W   = 17;
  localparam int SPEED_W  = 15;

  localparam logic signed [31:0] PRES_GAIN   = 32'sd6600;
  localparam logic signed [31:0] PRES_OFFSET = 32'sd163840000;
  localparam logic [9:0]         RHO_UNIT    = 10'd1000;
  localparam logic [19:0]        CAL_GAIN    = 20'd200;
  localparam logic signed [20:0] CAL_MID     = 21'sd310303;
  localparam logic [4:0]         DEN_GAIN    = 5'd25;

  localparam logic signed [BIAS_W-1:0] BIAS_HIGH = 17'sh0FFFF;
  localparam logic signed [BIAS_W-1:0] BIAS_LOW  = 17'sh10000;
  localparam int BIAS_HIGH_MAG = 65535;
  localparam int BIAS_LOW_MAG  = 65536;

  localparam logic [ROM_W-1:0] DENSITY_ROM [ROM_SIZE] = '{
    11'd1368, 11'd1363, 11'd1358, 11'd1353, 11'd1348, 11'd1342, 11'd1337, 11'd1332,
    11'd1327, 11'd1322, 11'd1317, 11'd1312, 11'd1308, 11'd1303, 11'd1298, 11'd1293,
    11'd1288, 11'd1284, 11'd1279, 11'd1275, 11'd1270, 11'd1265, 11'd1261, 11'd1256,
    11'd1252, 11'd1248, 11'd1243, 11'd1239, 11'd1235, 11'd1230, 11'd1226, 11'd1222,
    11'd1217, 11'd1213, 11'd1209, 11'd1205, 11'd1201, 11'd1197, 11'd1193, 11'd1189,
    11'd1185, 11'd1181, 11'd1177, 11'd1173, 11'd1169, 11'd1165, 11'd1161, 11'd1157,
    11'd1154, 11'd1150, 11'd1146, 11'd1142, 11'd1139, 11'd1135, 11'd1132, 11'd1128,
    11'd1124, 11'd1121, 11'd1117, 11'd1114, 11'd1110, 11'd1107, 11'd1103, 11'd1100,
    11'd1096, 11'd1093
  };

endpackage

FILE: design/pitot_rho.sv
module pitot_rho #(
  parameter int DENSITY_ENTRIES = 66
) (
  input  logic                          clk_i,
  input  logic signed [15:0]            temp_i,
  output logic [pitot_pkg::RHO_W-1:0]   rho_o
);

  localparam int TOP = ((DENSITY_ENTRIES < pitot_pkg::ROM_SIZE) ?
                        DENSITY_ENTRIES : pitot_pkg::ROM_SIZE) - 1;
  localparam logic signed [17:0] T_LO  = -18'sd3840;
  localparam logic signed [17:0] T_HI  = 18'((TOP - 15) * 256);
  localparam logic signed [17:0] T_OFS = 18'sd3840;

  logic signed [17:0]                  temp_x;
  logic signed [17:0]                  temp_c;
  logic signed [17:0]                  t_w;
  logic [pitot_pkg::IDX_W-1:0]         idx_w;
  logic [pitot_pkg::IDX_W-1:0]         nx_w;
  logic [7:0]                          frac_w;
  logic [pitot_pkg::ROM_W-1:0]         base_w;
  logic [pitot_pkg::ROM_W-1:0]         next_w;
  logic signed [11:0]                  step_w;
  logic signed [20:0]                  prod_w;
  logic signed [21:0]                  rho_w;
  logic [pitot_pkg::RHO_W-1:0]         rho_q;

  always_comb begin
    temp_x = {{2{temp_i[15]}}, temp_i};
    if (temp_x < T_LO) begin
      temp_c = T_LO;
    end else if (temp_x > T_HI) begin
      temp_c = T_HI;
    end else begin
      temp_c = temp_x;
    end
    t_w    = temp_c + T_OFS;
    idx_w  = t_w[pitot_pkg::IDX_W+7:8];
    frac_w = t_w[7:0];
    nx_w   = (idx_w >= pitot_pkg::IDX_W'(TOP)) ? idx_w : idx_w + 1'b1;
    base_w = pitot_pkg::DENSITY_ROM[idx_w];
    next_w = pitot_pkg::DENSITY_ROM[nx_w];
    step_w = $signed({1'b0, next_w}) - $signed({1'b0, base_w});
    prod_w = step_w * $signed({1'b0, frac_w});
    rho_w  = $signed({3'b000, base_w, 8'h00}) + prod_w;
  end

  always_ff @(posedge clk_i) begin
    rho_q <= rho_w[pitot_pkg::RHO_W-1:0];
  end

  assign rho_o = rho_q;

endmodule

FILE: design/pitot_iter.sv
module pitot_iter #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pitot_pkg::pitot_iter_req_t    req_i,
  input  logic [NUM_W-1:0]              num_i,
  input  logic [DEN_W-1:0]              den_i,
  output logic                          busy_o,
  output logic [NUM_W-1:0]              quot_o,
  output logic [pitot_pkg::ROOT_W-1:0]  root_o
);

  localparam int REM_W = DEN_W + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic                          busy_q;
  pitot_pkg::pitot_mode_e        mode_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [NUM_W-1:0]              acc_q;
  logic [REM_W-1:0]              rem_q;
  logic [DEN_W-1:0]              den_q;
  logic [pitot_pkg::ROOT_W-1:0]  root_q;

  logic [REM_W-1:0]              op_a;
  logic [REM_W-1:0]              op_b;
  logic [REM_W:0]                diff_w;
  logic                          ge_w;
  logic [REM_W-1:0]              rem_d;

  always_comb begin
    if (mode_q == pitot_pkg::MODE_SQRT) begin
      op_a = {rem_q[REM_W-3:0], acc_q[pitot_pkg::SQRT_W-1 -: 2]};
      op_b = REM_W'({root_q, 2'b01});
    end else begin
      op_a = {rem_q[REM_W-2:0], acc_q[NUM_W-1]};
      op_b = {1'b0, den_q};
    end
    diff_w = {1'b0, op_a} - {1'b0, op_b};
    ge_w   = ~diff_w[REM_W];
    rem_d  = ge_w ? diff_w[REM_W-1:0] : op_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mode_q <= pitot_pkg::MODE_DIV;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      mode_q <= req_i.mode;
      cnt_q  <= (req_i.mode == pitot_pkg::MODE_SQRT) ?
                CNT_W'(pitot_pkg::ROOT_W) : CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      if (mode_q == pitot_pkg::MODE_SQRT) begin
        acc_q  <= {acc_q[NUM_W-3:0], 2'b00};
        root_q <= {root_q[pitot_pkg::ROOT_W-2:0], ge_w};
      end else begin
        acc_q <= {acc_q[NUM_W-2:0], ge_w};
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = acc_q;
  assign root_o = root_q;

endmodule

FILE: design/pitot_airspeed_with_offset_calibration_top.sv
// Pitot airspeed with zero-offset calibration.
// Input channel (in_valid_i/in_ready_o) carries one request: kind_i, a 12-bit
// pressure sample and a Q7.8 temperature. Output channel (out_valid_o/
// out_ready_i) returns exactly one result per request: airspeed in 1/256 m/s,
// the current bias in 1/16 counts, and a flag set by a finish request.
// One request is worked on at a time. A measure request runs one restoring
// divide (NUM_W steps, 49 at default) and one square root (16 steps) on the
// shared compare-subtract unit; a finish request runs one divide for the bias.
// The shared unit sets the throughput.
// The result sits in an output register; the next request is taken while it
// waits, but its own result is held back until the register is free, so a
// stalled receiver stops the block after one further request.
// Reset clears the bias, the calibration sum and count, and empties the
// output register.
module pitot_airspeed_with_offset_calibration_top #(
  parameter int DENSITY_ENTRIES = 66,
  parameter int COUNT_BITS      = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [11:0]        adc_sample_i,
  input  logic signed [15:0] temperature_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [14:0]        air_speed_o,
  output logic signed [16:0] bias_out_o,
  output logic               bias_updated_o
);

  localparam int SUM_W = COUNT_BITS + pitot_pkg::TERM_W;
  localparam int AN_W  = SUM_W + 2;
  localparam int DEN_W = (COUNT_BITS + 5 > pitot_pkg::RHO_W) ?
                         COUNT_BITS + 5 : pitot_pkg::RHO_W;
  localparam int NUM_W = (AN_W > pitot_pkg::SCALE_W) ? AN_W : pitot_pkg::SCALE_W;

  pitot_pkg::pitot_state_e            state_q, state_d;
  logic [1:0]                         kind_q;
  logic [11:0]                        adc_q;
  logic signed [15:0]                 temp_q;
  logic [pitot_pkg::MAG_W-1:0]        mag_q;
  logic [pitot_pkg::SPEED_W-1:0]      speed_q;
  logic signed [pitot_pkg::BIAS_W-1:0] bias_q;
  logic signed [SUM_W-1:0]            sum_q;
  logic [COUNT_BITS-1:0]              count_q;
  logic                               out_valid_q;
  logic [pitot_pkg::SPEED_W-1:0]      out_speed_q;
  logic signed [pitot_pkg::BIAS_W-1:0] out_bias_q;
  logic                               out_upd_q;

  logic [pitot_pkg::RHO_W-1:0]        rho_w;
  pitot_pkg::pitot_iter_req_t         req_w;
  logic [NUM_W-1:0]                   num_w;
  logic [DEN_W-1:0]                   den_sel_w;
  logic                               busy_w;
  logic [NUM_W-1:0]                   quot_w;
  logic [pitot_pkg::ROOT_W-1:0]       root_w;
  logic                               in_take;
  logic                               out_load;

  logic signed [17:0]                 diff_w;
  logic signed [31:0]                 prod_w;
  logic signed [31:0]                 pn_w;
  logic [pitot_pkg::MAG_W-1:0]        mag_w;
  logic [pitot_pkg::MUL_W-1:0]        scaled_w;
  logic [19:0]                        adc_x_w;
  logic signed [20:0]                 term_w;
  logic                               count_full;
  logic [DEN_W-1:0]                   den_w;
  logic                               sum_neg;
  logic [SUM_W-1:0]                   sum_abs;
  logic [AN_W-1:0]                    an_w;
  logic signed [pitot_pkg::BIAS_W-1:0] bias_new;
  logic [pitot_pkg::SPEED_W-1:0]      speed_sat;

  pitot_rho #(
    .DENSITY_ENTRIES(DENSITY_ENTRIES)
  ) u_rho (
    .clk_i (clk_i),
    .temp_i(temp_q),
    .rho_o (rho_w)
  );

  pitot_iter #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_iter (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_w),
    .num_i (num_w),
    .den_i (den_sel_w),
    .busy_o(busy_w),
    .quot_o(quot_w),
    .root_o(root_w)
  );

  always_comb begin
    diff_w   = $signed({2'b00, adc_q, 4'b0000}) - $signed({bias_q[16], bias_q});
    prod_w   = diff_w * pitot_pkg::PRES_GAIN;
    pn_w     = prod_w - pitot_pkg::PRES_OFFSET;
    mag_w    = pn_w[31] ? pitot_pkg::MAG_W'(-pn_w) : pitot_pkg::MAG_W'(pn_w);
    scaled_w = pitot_pkg::MUL_W'(mag_q) * pitot_pkg::MUL_W'(pitot_pkg::RHO_UNIT);

    adc_x_w    = 20'(adc_q) * pitot_pkg::CAL_GAIN;
    term_w     = $signed({1'b0, adc_x_w}) - pitot_pkg::CAL_MID;
    count_full = &count_q;

    den_w   = DEN_W'(count_q) * DEN_W'(pitot_pkg::DEN_GAIN);
    sum_neg = sum_q[SUM_W-1];
    sum_abs = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    an_w    = {1'b0, sum_abs, 1'b0} + AN_W'(den_w >> 1);

    if (!sum_neg) begin
      bias_new = (quot_w > NUM_W'(pitot_pkg::BIAS_HIGH_MAG)) ?
                 pitot_pkg::BIAS_HIGH : $signed(quot_w[pitot_pkg::BIAS_W-1:0]);
    end else begin
      bias_new = (quot_w > NUM_W'(pitot_pkg::BIAS_LOW_MAG)) ?
                 pitot_pkg::BIAS_LOW : -$signed(quot_w[pitot_pkg::BIAS_W-1:0]);
    end

    speed_sat = root_w[pitot_pkg::ROOT_W-1] ? '1 : root_w[pitot_pkg::SPEED_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pitot_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = pitot_pkg::ST_PRES;
        end
      end
      pitot_pkg::ST_PRES: begin
        case (kind_q)
          pitot_pkg::KIND_MEASURE: state_d = pitot_pkg::ST_SCALE;
          pitot_pkg::KIND_CAL:     state_d = pitot_pkg::ST_ACC;
          pitot_pkg::KIND_FINISH:  state_d = pitot_pkg::ST_ACC;
          default:                 state_d = pitot_pkg::ST_DONE;
        endcase
      end
      pitot_pkg::ST_SCALE: state_d = pitot_pkg::ST_DIV;
      pitot_pkg::ST_DIV: begin
        if (!busy_w) begin
          state_d = pitot_pkg::ST_SQRT_GO;
        end
      end
      pitot_pkg::ST_SQRT_GO: state_d = pitot_pkg::ST_SQRT;
      pitot_pkg::ST_SQRT: begin
        if (!busy_w) begin
          state_d = pitot_pkg::ST_DONE;
        end
      end
      pitot_pkg::ST_ACC: begin
        state_d = (kind_q == pitot_pkg::KIND_FINISH) ? pitot_pkg::ST_BIAS_GO :
                                                       pitot_pkg::ST_DONE;
      end
      pitot_pkg::ST_BIAS_GO: state_d = pitot_pkg::ST_BIAS_DIV;
      pitot_pkg::ST_BIAS_DIV: begin
        if (!busy_w) begin
          state_d = pitot_pkg::ST_BIAS_SET;
        end
      end
      pitot_pkg::ST_BIAS_SET: state_d = pitot_pkg::ST_DONE;
      pitot_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = pitot_pkg::ST_IDLE;
        end
      end
      default: state_d = pitot_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    req_w      = '{start: 1'b0, mode: pitot_pkg::MODE_DIV};
    num_w      = '0;
    den_sel_w  = '0;
    case (state_q)
      pitot_pkg::ST_IDLE: in_ready_o = 1'b1;
      pitot_pkg::ST_SCALE: begin
        req_w     = '{start: 1'b1, mode: pitot_pkg::MODE_DIV};
        num_w     = NUM_W'({scaled_w, 9'h000});
        den_sel_w = DEN_W'(rho_w);
      end
      pitot_pkg::ST_SQRT_GO: begin
        req_w = '{start: 1'b1, mode: pitot_pkg::MODE_SQRT};
        num_w = NUM_W'(quot_w[pitot_pkg::SQRT_W-1:0]);
      end
      pitot_pkg::ST_BIAS_GO: begin
        req_w     = '{start: 1'b1, mode: pitot_pkg::MODE_DIV};
        num_w     = NUM_W'(an_w);
        den_sel_w = den_w;
      end
      pitot_pkg::ST_DONE: out_load = !out_valid_q || out_ready_i;
      default: begin
      end
    endcase
  end

  assign in_take = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pitot_pkg::ST_IDLE;
      bias_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == pitot_pkg::ST_ACC && !count_full) begin
        count_q <= count_q + 1'b1;
        sum_q   <= sum_q + {{(SUM_W-21){term_w[20]}}, term_w};
      end
      if (state_q == pitot_pkg::ST_BIAS_SET) begin
        bias_q  <= bias_new;
        sum_q   <= '0;
        count_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q  <= kind_i;
      adc_q   <= adc_sample_i;
      temp_q  <= temperature_i;
      speed_q <= '0;
    end
    if (state_q == pitot_pkg::ST_PRES) begin
      mag_q <= mag_w;
    end
    if (state_q == pitot_pkg::ST_SQRT && !busy_w) begin
      speed_q <= speed_sat;
    end
    if (out_load) begin
      out_speed_q <= speed_q;
      out_bias_q  <= bias_q;
      out_upd_q   <= (kind_q == pitot_pkg::KIND_FINISH);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign air_speed_o    = out_speed_q;
  assign bias_out_o     = out_bias_q;
  assign bias_updated_o = out_upd_q;

endmodule

FILE: design/pitot_chk.sv
module pitot_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         kind_i,
  input logic [11:0]        adc_sample_i,
  input logic signed [15:0] temperature_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [14:0]        air_speed_o,
  input logic signed [16:0] bias_out_o,
  input logic               bias_updated_o
);

  logic unused_in;
  assign unused_in = ^{kind_i, adc_sample_i, temperature_i};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(air_speed_o) &&
      $stable(bias_out_o) && $stable(bias_updated_o))
    else $error("stalled result changed");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("request taken while busy");

  a_finish_no_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bias_updated_o |-> air_speed_o == 15'd0)
    else $error("finish result carries airspeed");

  a_bias_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i ##1 out_valid_o && !bias_updated_o
      |-> bias_out_o == $past(bias_out_o))
    else $error("bias moved without update");

endmodule

bind pitot_airspeed_with_offset_calibration_top pitot_chk u_pitot_chk (.*);
